>>> sv/rrpq_pkg.sv
// ----------------------------------------------------------------------------
// rrpq_pkg
// Shared codes, command and status types for the process queue scheduler.
// ----------------------------------------------------------------------------
package rrpq_pkg;

   localparam int NUM_SLOTS_DEF = 32;

   localparam logic [2:0] OP_FORK     = 3'd0;
   localparam logic [2:0] OP_SCHEDULE = 3'd1;
   localparam logic [2:0] OP_SUSPEND  = 3'd2;
   localparam logic [2:0] OP_WAKEUP   = 3'd3;
   localparam logic [2:0] OP_DESTROY  = 3'd4;

   typedef enum logic [1:0] {
      ST_FREE   = 2'd0,
      ST_RUN    = 2'd1,
      ST_WAIT   = 2'd2,
      ST_ZOMBIE = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      RSP_OK        = 2'd0,
      RSP_NO_FREE   = 2'd1,
      RSP_NO_RUN    = 2'd2,
      RSP_BAD_STATE = 2'd3
   } rsp_code_type;

   typedef enum logic [2:0] {
      DP_NOP    = 3'd0,
      DP_INIT   = 3'd1,
      DP_UNLINK = 3'd2,
      DP_APP_A  = 3'd3,
      DP_APP_B  = 3'd4,
      DP_PF_A   = 3'd5,
      DP_PF_B   = 3'd6
   } dp_op_type;

   typedef enum logic [2:0] {
      TGT_HOLD        = 3'd0,
      TGT_FREE_HEAD   = 3'd1,
      TGT_RUN_HEAD    = 3'd2,
      TGT_ZOMBIE_HEAD = 3'd3,
      TGT_SLOT        = 3'd4
   } tgt_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD     = 2'd0,
      CUR_FORK     = 2'd1,
      CUR_RUN_HEAD = 2'd2
   } cur_mode_type;

   typedef struct packed {
      dp_op_type      op;
      slot_state_type queue;
      tgt_sel_type    tgt_sel;
      cur_mode_type   cur_mode;
      logic           take_req;
      logic           load_rsp;
      logic           grant;
      rsp_code_type   code;
   } dp_cmd_type;

   typedef struct packed {
      logic           init_last;
      logic           free_empty;
      logic           run_empty;
      logic           zombie_empty;
      logic           slot_in_range;
      slot_state_type rd_state;
   } dp_stat_type;

endpackage

>>> sv/rrpq_datapath.sv
// ----------------------------------------------------------------------------
// rrpq_datapath
// Slot link memories, queue head/tail/count registers and result registers.
// ----------------------------------------------------------------------------
module rrpq_datapath import rrpq_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [4:0]  req_slot,
   output dp_stat_type stat,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_new_slot,
   output logic [4:0]  rsp_current_slot,
   output logic        rsp_current_valid
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);

   slot_state_type state_mem [NUM_SLOTS];
   logic [IW-1:0]  next_mem  [NUM_SLOTS];
   logic [IW-1:0]  prev_mem  [NUM_SLOTS];

   logic [IW-1:0] head_ff [4];
   logic [IW-1:0] head_in [4];
   logic [IW-1:0] tail_ff [4];
   logic [IW-1:0] tail_in [4];
   logic [CW-1:0] cnt_ff  [4];
   logic [CW-1:0] cnt_in  [4];

   logic [IW-1:0]  init_ff, init_in;
   logic [IW-1:0]  tgt_ff, tgt_in;
   logic [IW-1:0]  slot_ff;
   logic           in_range_ff;
   slot_state_type rd_state_ff;
   logic [IW-1:0]  rd_next_ff, rd_prev_ff;
   logic [IW-1:0]  cur_ff, cur_in;
   logic           cur_set_ff, cur_set_in;

   logic [1:0]  rsp_status_ff;
   logic [4:0]  rsp_new_slot_ff, rsp_current_ff;
   logic        rsp_cur_valid_ff;

   logic           st_we, nx_we, pv_we;
   logic [IW-1:0]  st_addr, nx_addr, pv_addr;
   slot_state_type st_data;
   logic [IW-1:0]  nx_data, pv_data;

   logic [31:0]   slot_wide, tgt_wide, cur_wide;
   logic [CW-1:0] cnt_q;

   assign slot_wide = 32'(req_slot);
   assign tgt_wide  = 32'(tgt_ff);
   assign cur_wide  = 32'(cur_in);
   assign cnt_q     = cnt_ff[cmd.queue];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         cnt_in[i]  = cnt_ff[i];
      end
      init_in = init_ff;
      st_we = 1'b0; st_addr = tgt_ff; st_data = cmd.queue;
      nx_we = 1'b0; nx_addr = tgt_ff; nx_data = '0;
      pv_we = 1'b0; pv_addr = tgt_ff; pv_data = '0;
      case (cmd.op)
         DP_INIT: begin
            init_in = init_ff + 1'b1;
            st_we = 1'b1; st_addr = init_ff; st_data = ST_FREE;
            nx_we = 1'b1; nx_addr = init_ff;
            nx_data = (init_ff == '0) ? '0 : init_ff - 1'b1;
            pv_we = 1'b1; pv_addr = init_ff;
            pv_data = (init_ff == IW'(NUM_SLOTS - 1)) ? '0 : init_ff + 1'b1;
         end
         DP_UNLINK: begin
            // The slot leaves the queue of the state it was read in.
            if (cnt_ff[rd_state_ff] != '0) begin
               if (head_ff[rd_state_ff] == tgt_ff) begin
                  head_in[rd_state_ff] = rd_next_ff;
               end else begin
                  nx_we = 1'b1; nx_addr = rd_prev_ff; nx_data = rd_next_ff;
               end
               if (tail_ff[rd_state_ff] == tgt_ff) begin
                  tail_in[rd_state_ff] = rd_prev_ff;
               end else begin
                  pv_we = 1'b1; pv_addr = rd_next_ff; pv_data = rd_prev_ff;
               end
               cnt_in[rd_state_ff] = cnt_ff[rd_state_ff] - 1'b1;
               if (cnt_ff[rd_state_ff] == CW'(1)) begin
                  head_in[rd_state_ff] = '0;
                  tail_in[rd_state_ff] = '0;
               end
            end
         end
         DP_APP_A: begin
            st_we = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            pv_data = (cnt_q != '0) ? tail_ff[cmd.queue] : '0;
            if (cnt_q == '0) begin
               head_in[cmd.queue] = tgt_ff;
            end
         end
         DP_APP_B: begin
            if (cnt_q != '0) begin
               nx_we = 1'b1; nx_addr = tail_ff[cmd.queue]; nx_data = tgt_ff;
            end
            tail_in[cmd.queue] = tgt_ff;
            cnt_in[cmd.queue]  = cnt_q + 1'b1;
         end
         DP_PF_A: begin
            st_we = 1'b1;
            pv_we = 1'b1;
            nx_we = 1'b1;
            nx_data = (cnt_q != '0) ? head_ff[cmd.queue] : '0;
            if (cnt_q == '0) begin
               tail_in[cmd.queue] = tgt_ff;
            end
         end
         DP_PF_B: begin
            if (cnt_q != '0) begin
               pv_we = 1'b1; pv_addr = head_ff[cmd.queue]; pv_data = tgt_ff;
            end
            head_in[cmd.queue] = tgt_ff;
            cnt_in[cmd.queue]  = cnt_q + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (cmd.tgt_sel)
         TGT_FREE_HEAD:   tgt_in = head_ff[ST_FREE];
         TGT_RUN_HEAD:    tgt_in = head_ff[ST_RUN];
         TGT_ZOMBIE_HEAD: tgt_in = head_ff[ST_ZOMBIE];
         TGT_SLOT:        tgt_in = slot_ff;
         default:         tgt_in = tgt_ff;
      endcase
   end

   always_comb begin
      cur_in     = cur_ff;
      cur_set_in = cur_set_ff;
      case (cmd.cur_mode)
         CUR_FORK: begin
            if (!cur_set_ff) begin
               cur_in     = tgt_ff;
               cur_set_in = 1'b1;
            end
         end
         CUR_RUN_HEAD: begin
            cur_in     = head_ff[ST_RUN];
            cur_set_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) state_mem[st_addr] <= st_data;
      if (nx_we) next_mem[nx_addr] <= nx_data;
      if (pv_we) prev_mem[pv_addr] <= pv_data;
      rd_state_ff <= state_mem[tgt_ff];
      rd_next_ff  <= next_mem[tgt_ff];
      rd_prev_ff  <= prev_mem[tgt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         head_ff[ST_FREE] <= IW'(NUM_SLOTS - 1);
         cnt_ff[ST_FREE]  <= CW'(NUM_SLOTS);
         init_ff    <= '0;
         cur_ff     <= '0;
         cur_set_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
         init_ff    <= init_in;
         cur_ff     <= cur_in;
         cur_set_ff <= cur_set_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      if (cmd.take_req) begin
         slot_ff     <= slot_wide[IW-1:0];
         in_range_ff <= slot_wide < 32'(NUM_SLOTS);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff    <= cmd.code;
         rsp_new_slot_ff  <= cmd.grant ? tgt_wide[4:0] : 5'd0;
         rsp_current_ff   <= cur_wide[4:0];
         rsp_cur_valid_ff <= cur_set_in;
      end
   end

   assign stat.init_last     = (init_ff == IW'(NUM_SLOTS - 1));
   assign stat.free_empty    = (cnt_ff[ST_FREE] == '0);
   assign stat.run_empty     = (cnt_ff[ST_RUN] == '0);
   assign stat.zombie_empty  = (cnt_ff[ST_ZOMBIE] == '0);
   assign stat.slot_in_range = in_range_ff;
   assign stat.rd_state      = rd_state_ff;

   assign rsp_status        = rsp_status_ff;
   assign rsp_new_slot      = rsp_new_slot_ff;
   assign rsp_current_slot  = rsp_current_ff;
   assign rsp_current_valid = rsp_cur_valid_ff;

endmodule

>>> sv/rrpq_control.sv
// ----------------------------------------------------------------------------
// rrpq_control
// Sequencer that breaks each command into queue unlink and link steps.
// ----------------------------------------------------------------------------
module rrpq_control import rrpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  req_op,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [10:0] {
      S_INIT   = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_DECODE = 11'b000_0000_0100,
      S_READ   = 11'b000_0000_1000,
      S_UNLINK = 11'b000_0001_0000,
      S_APP_A  = 11'b000_0010_0000,
      S_APP_B  = 11'b000_0100_0000,
      S_PF_A   = 11'b000_1000_0000,
      S_PF_B   = 11'b001_0000_0000,
      S_DRAIN  = 11'b010_0000_0000,
      S_FINISH = 11'b100_0000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [2:0]     op_ff, op_in;
   logic           drain_ff, drain_in;
   rsp_code_type   code_ff, code_in;
   logic           rsp_valid_ff, rsp_valid_in;
   slot_state_type dest;

   always_comb begin
      if (drain_ff) begin
         dest = ST_FREE;
      end else if (op_ff == OP_SUSPEND) begin
         dest = ST_WAIT;
      end else begin
         dest = ST_RUN;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      drain_in     = drain_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.queue    = dest;
      cmd.code     = code_ff;
      case (state_ff)
         S_INIT: begin
            cmd.op = DP_INIT;
            if (stat.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               op_in    = req_op;
               drain_in = 1'b0;
               code_in  = RSP_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_READ;
            if (op_ff == OP_FORK) begin
               if (stat.free_empty) begin
                  code_in  = RSP_NO_FREE;
                  state_in = S_FINISH;
               end else begin
                  cmd.tgt_sel = TGT_FREE_HEAD;
               end
            end else if (op_ff == OP_SCHEDULE) begin
               if (stat.run_empty) begin
                  code_in  = RSP_NO_RUN;
                  state_in = S_FINISH;
               end else begin
                  cmd.tgt_sel = TGT_RUN_HEAD;
               end
            end else if (op_ff == OP_SUSPEND || op_ff == OP_WAKEUP ||
                         op_ff == OP_DESTROY) begin
               if (!stat.slot_in_range) begin
                  code_in  = RSP_BAD_STATE;
                  state_in = S_FINISH;
               end else begin
                  cmd.tgt_sel = TGT_SLOT;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            if ((op_ff == OP_SUSPEND && stat.rd_state != ST_RUN) ||
                (op_ff == OP_WAKEUP && stat.rd_state != ST_WAIT)) begin
               code_in  = RSP_BAD_STATE;
               state_in = S_FINISH;
            end else begin
               cmd.op   = DP_UNLINK;
               state_in = (op_ff == OP_DESTROY) ? S_PF_A : S_APP_A;
            end
         end
         S_APP_A: begin
            cmd.op   = DP_APP_A;
            state_in = S_APP_B;
         end
         S_APP_B: begin
            cmd.op   = DP_APP_B;
            state_in = (op_ff == OP_SCHEDULE) ? S_DRAIN : S_FINISH;
         end
         S_PF_A: begin
            cmd.op    = DP_PF_A;
            cmd.queue = ST_ZOMBIE;
            state_in  = S_PF_B;
         end
         S_PF_B: begin
            cmd.op    = DP_PF_B;
            cmd.queue = ST_ZOMBIE;
            state_in  = S_FINISH;
         end
         S_DRAIN: begin
            // The first visit follows the rotation, so the run head is the new current.
            if (!drain_ff) cmd.cur_mode = CUR_RUN_HEAD;
            if (!stat.zombie_empty) begin
               cmd.tgt_sel = TGT_ZOMBIE_HEAD;
               drain_in    = 1'b1;
               state_in    = S_READ;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               if (op_ff == OP_FORK && code_ff == RSP_OK) begin
                  cmd.grant    = 1'b1;
                  cmd.cur_mode = CUR_FORK;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
         op_ff        <= OP_FORK;
         code_ff      <= RSP_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         drain_ff     <= drain_in;
         op_ff        <= op_in;
         code_ff      <= code_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/round_robin_process_queues.sv
// ----------------------------------------------------------------------------
// round_robin_process_queues
// Process slot manager with free, run, wait and zombie queues.
// ----------------------------------------------------------------------------
// After reset the block builds the free chain in its link memories and
// accepts no command in that time. A command then runs as a sequence of
// sequencer steps, since the link memories have one write and one
// registered read port each. A fork with no free slot, a schedule with
// nothing runnable, a slot out of range and an unused code go from decode
// straight to the result. A suspend or wakeup of a slot in the wrong state
// first reads and checks the slot. A successful suspend, wakeup, fork or
// schedule reads, unlinks and appends the slot, a destroy prepends it to the
// zombie queue instead, and a schedule then returns each zombie slot to the
// free queue. The next command is taken once the current one has placed its
// result in the output register, which holds it until the result transfer.
// ----------------------------------------------------------------------------
module round_robin_process_queues import rrpq_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [4:0] req_slot,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_new_slot,
   output logic [4:0] rsp_current_slot,
   output logic       rsp_current_valid
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rrpq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrpq_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_slot          (req_slot),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_new_slot      (rsp_new_slot),
      .rsp_current_slot  (rsp_current_slot),
      .rsp_current_valid (rsp_current_valid)
   );

endmodule
